### hw/rtl/elsch_pkg.sv
// Shared types, constants and bitmap helpers for the LOOK elevator scheduler.
package elsch_pkg;

  localparam int NUM_FLOORS = 64;
  localparam int FLOOR_W    = 6;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [FLOOR_W-1:0] TOP_MAX = FLOOR_W'(NUM_FLOORS - 1);

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_MOVING  = 2'd1,
    PH_DOOR    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_TICK     = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_SAME     = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOP_FLOOR = 2'd0,
    CFG_TRAVEL    = 2'd1,
    CFG_DOOR      = 2'd2
  } cfg_reg_e;

  typedef logic [NUM_FLOORS-1:0] floor_map_t;

  // Result of target selection: chosen floor, new heading, and which set it came from.
  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    dir_e               dir;
    logic               from_up;
  } pick_t;

  // One result item; the lowest field sits in the lowest bits.
  typedef struct packed {
    status_e            status;
    logic [FLOOR_W-1:0] goal;
    logic               door;
    logic               moving;
    dir_e               dir;
    logic [FLOOR_W-1:0] floor;
  } res_t;

  localparam int RES_W = $bits(res_t);

  // Returns {found, index} of the lowest set bit.
  function automatic logic [FLOOR_W:0] lowest_bit(floor_map_t v);
    logic               found;
    logic [FLOOR_W-1:0] idx;
    found = 1'b0;
    idx   = '0;
    for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
      if (v[i]) begin
        found = 1'b1;
        idx   = FLOOR_W'(i);
      end
    end
    return {found, idx};
  endfunction

  // Returns {found, index} of the highest set bit.
  function automatic logic [FLOOR_W:0] highest_bit(floor_map_t v);
    logic               found;
    logic [FLOOR_W-1:0] idx;
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (v[i]) begin
        found = 1'b1;
        idx   = FLOOR_W'(i);
      end
    end
    return {found, idx};
  endfunction

  function automatic floor_map_t mask_above(logic [FLOOR_W-1:0] p);
    floor_map_t m;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      m[i] = ((FLOOR_W + 1)'(i) > {1'b0, p});
    end
    return m;
  endfunction

  function automatic floor_map_t mask_below(logic [FLOOR_W-1:0] p);
    floor_map_t m;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      m[i] = ((FLOOR_W + 1)'(i) < {1'b0, p});
    end
    return m;
  endfunction

  function automatic floor_map_t floor_bit(logic [FLOOR_W-1:0] f);
    floor_map_t m;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      m[i] = ((FLOOR_W + 1)'(i) == {1'b0, f});
    end
    return m;
  endfunction

endpackage

### hw/rtl/elsch_pick.sv
// LOOK target selection over the up and down request bitmaps.
module elsch_pick (
  input  elsch_pkg::floor_map_t              up_i,
  input  elsch_pkg::floor_map_t              down_i,
  input  logic [elsch_pkg::FLOOR_W-1:0]      floor_i,
  input  elsch_pkg::dir_e                    heading_i,
  output elsch_pkg::pick_t                   pick_o
);

  logic [elsch_pkg::FLOOR_W:0] up_above;
  logic [elsch_pkg::FLOOR_W:0] down_below;
  logic [elsch_pkg::FLOOR_W:0] up_lo;
  logic [elsch_pkg::FLOOR_W:0] up_hi;
  logic [elsch_pkg::FLOOR_W:0] down_lo;
  logic [elsch_pkg::FLOOR_W:0] down_hi;
  logic                        here_up;
  logic                        here_down;
  logic [elsch_pkg::FLOOR_W:0] near_sum;
  logic                        up_nearer;

  assign up_above   = elsch_pkg::lowest_bit(up_i & elsch_pkg::mask_above(floor_i));
  assign down_below = elsch_pkg::highest_bit(down_i & elsch_pkg::mask_below(floor_i));
  assign up_lo      = elsch_pkg::lowest_bit(up_i);
  assign up_hi      = elsch_pkg::highest_bit(up_i);
  assign down_lo    = elsch_pkg::lowest_bit(down_i);
  assign down_hi    = elsch_pkg::highest_bit(down_i);
  assign here_up    = up_i[floor_i];
  assign here_down  = down_i[floor_i];

  // (lo - f) <= (f - hi) is the same as lo + hi <= 2f.
  assign near_sum  = {1'b0, up_lo[elsch_pkg::FLOOR_W-1:0]}
                   + {1'b0, down_hi[elsch_pkg::FLOOR_W-1:0]};
  assign up_nearer = near_sum <= {floor_i, 1'b0};

  always_comb begin
    pick_o = '{floor: floor_i, dir: elsch_pkg::DIR_UP, from_up: 1'b1};
    if (here_up) begin
      pick_o = '{floor: floor_i, dir: elsch_pkg::DIR_UP, from_up: 1'b1};
    end else if (here_down) begin
      pick_o = '{floor: floor_i, dir: elsch_pkg::DIR_UP, from_up: 1'b0};
    end else begin
      case (heading_i)
        elsch_pkg::DIR_UP: begin
          if (up_above[elsch_pkg::FLOOR_W]) begin
            pick_o = '{floor: up_above[elsch_pkg::FLOOR_W-1:0],
                       dir: elsch_pkg::DIR_UP, from_up: 1'b1};
          end else if (down_hi[elsch_pkg::FLOOR_W]) begin
            pick_o = '{floor: down_hi[elsch_pkg::FLOOR_W-1:0],
                       dir: elsch_pkg::DIR_DOWN, from_up: 1'b0};
          end else begin
            pick_o = '{floor: up_hi[elsch_pkg::FLOOR_W-1:0],
                       dir: elsch_pkg::DIR_DOWN, from_up: 1'b1};
          end
        end
        elsch_pkg::DIR_DOWN: begin
          if (down_below[elsch_pkg::FLOOR_W]) begin
            pick_o = '{floor: down_below[elsch_pkg::FLOOR_W-1:0],
                       dir: elsch_pkg::DIR_DOWN, from_up: 1'b0};
          end else if (up_lo[elsch_pkg::FLOOR_W]) begin
            pick_o = '{floor: up_lo[elsch_pkg::FLOOR_W-1:0],
                       dir: elsch_pkg::DIR_UP, from_up: 1'b1};
          end else begin
            pick_o = '{floor: down_lo[elsch_pkg::FLOOR_W-1:0],
                       dir: elsch_pkg::DIR_UP, from_up: 1'b0};
          end
        end
        default: begin
          // Idle: the nearer of the lowest up and highest down request, up on a tie.
          if (up_lo[elsch_pkg::FLOOR_W] && (!down_hi[elsch_pkg::FLOOR_W] || up_nearer)) begin
            pick_o = '{floor: up_lo[elsch_pkg::FLOOR_W-1:0],
                       dir: elsch_pkg::DIR_UP, from_up: 1'b1};
          end else begin
            pick_o = '{floor: down_hi[elsch_pkg::FLOOR_W-1:0],
                       dir: elsch_pkg::DIR_DOWN, from_up: 1'b0};
          end
        end
      endcase
    end
  end

endmodule

### hw/rtl/elsch_core.sv
// Car state registers and the per-item update for requests and ticks.
module elsch_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                commit_i,
  input  elsch_pkg::op_e                      op_i,
  input  logic [elsch_pkg::FLOOR_W-1:0]       req_floor_i,
  input  logic [elsch_pkg::FLOOR_W-1:0]       top_floor_i,
  input  logic [elsch_pkg::TICK_W-1:0]        travel_ticks_i,
  input  logic [elsch_pkg::TICK_W-1:0]        door_ticks_i,
  output elsch_pkg::res_t                     res_o
);

  elsch_pkg::floor_map_t              up_q, up_d;
  elsch_pkg::floor_map_t              down_q, down_d;
  logic [elsch_pkg::FLOOR_W-1:0]      floor_q, floor_d;
  elsch_pkg::dir_e                    head_q, head_d;
  elsch_pkg::phase_e                  phase_q, phase_d;
  logic [elsch_pkg::FLOOR_W-1:0]      target_q, target_d;
  logic [elsch_pkg::TICK_W-1:0]       cnt_q, cnt_d;

  elsch_pkg::pick_t                   pick;
  elsch_pkg::status_e                 status;
  logic [elsch_pkg::FLOOR_W-1:0]      top_eff;
  logic [elsch_pkg::TICK_W:0]         cnt_inc;
  logic [elsch_pkg::FLOOR_W-1:0]      floor_step;

  elsch_pick u_pick (
    .up_i      (up_q),
    .down_i    (down_q),
    .floor_i   (floor_q),
    .heading_i (head_q),
    .pick_o    (pick)
  );

  assign top_eff = (top_floor_i > elsch_pkg::TOP_MAX) ? elsch_pkg::TOP_MAX : top_floor_i;
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;

  always_comb begin
    if (target_q > floor_q) begin
      floor_step = floor_q + 1'b1;
    end else if (target_q < floor_q) begin
      floor_step = floor_q - 1'b1;
    end else begin
      floor_step = floor_q;
    end
  end

  always_comb begin
    up_d     = up_q;
    down_d   = down_q;
    floor_d  = floor_q;
    head_d   = head_q;
    phase_d  = phase_q;
    target_d = target_q;
    cnt_d    = cnt_q;
    status   = elsch_pkg::ST_TICK;

    if (op_i == elsch_pkg::OP_REQUEST) begin
      if (req_floor_i > top_eff) begin
        status = elsch_pkg::ST_RANGE;
      end else if (req_floor_i == floor_q) begin
        status = elsch_pkg::ST_SAME;
      end else begin
        status = elsch_pkg::ST_ACCEPTED;
        if (req_floor_i > floor_q) begin
          up_d = up_q | elsch_pkg::floor_bit(req_floor_i);
        end else begin
          down_d = down_q | elsch_pkg::floor_bit(req_floor_i);
        end
      end
    end else begin
      case (phase_q)
        elsch_pkg::PH_STOPPED: begin
          if (!(|up_q) && !(|down_q)) begin
            head_d = elsch_pkg::DIR_IDLE;
          end else begin
            target_d = pick.floor;
            head_d   = pick.dir;
            cnt_d    = '0;
            if (pick.from_up) begin
              up_d = up_q & ~elsch_pkg::floor_bit(pick.floor);
            end else begin
              down_d = down_q & ~elsch_pkg::floor_bit(pick.floor);
            end
            phase_d = (pick.floor == floor_q) ? elsch_pkg::PH_DOOR : elsch_pkg::PH_MOVING;
          end
        end
        elsch_pkg::PH_MOVING: begin
          // A period of zero behaves like one since the incremented count is compared.
          if (cnt_inc >= {1'b0, travel_ticks_i}) begin
            cnt_d   = '0;
            floor_d = floor_step;
            if (floor_step == target_q) begin
              phase_d = elsch_pkg::PH_DOOR;
            end
          end else begin
            cnt_d = cnt_inc[elsch_pkg::TICK_W-1:0];
          end
        end
        default: begin
          if (cnt_inc >= {1'b0, door_ticks_i}) begin
            cnt_d   = '0;
            phase_d = elsch_pkg::PH_STOPPED;
          end else begin
            cnt_d = cnt_inc[elsch_pkg::TICK_W-1:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    res_o.status = status;
    res_o.goal   = (phase_d == elsch_pkg::PH_STOPPED) ? '0 : target_d;
    res_o.door   = (phase_d == elsch_pkg::PH_DOOR);
    res_o.moving = (phase_d == elsch_pkg::PH_MOVING);
    res_o.dir    = head_d;
    res_o.floor  = floor_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q     <= '0;
      down_q   <= '0;
      floor_q  <= '0;
      head_q   <= elsch_pkg::DIR_IDLE;
      phase_q  <= elsch_pkg::PH_STOPPED;
      target_q <= '0;
      cnt_q    <= '0;
    end else if (commit_i) begin
      up_q     <= up_d;
      down_q   <= down_d;
      floor_q  <= floor_d;
      head_q   <= head_d;
      phase_q  <= phase_d;
      target_q <= target_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### hw/rtl/elevator_look_scheduler.sv
// Single-car LOOK elevator scheduler: stream wrapper, configuration and result register.
//
// Input stream s_axis: tuser carries the opcode (0 one time tick, 1 floor request),
// tdata[5:0] the requested floor. Every input transfer yields exactly one result
// transfer on m_axis, in order, carrying the car floor, heading, moving and door
// flags, goal floor and request status.
// Configuration: cfg_valid_i/cfg_ready_o write cfg_data_i into the register picked
// by cfg_index_i (0 top floor, 1 travel ticks, 2 door ticks); other indexes are
// ignored. cfg_ready_o is always high. Writes belong to times when no item is in flight.
// Path: an item is registered in the input register on entry, evaluated by one
// pass of priority encoders over the two request bitmaps once the result register can
// take it, and lands in the result register, which drives m_axis.
// Throughput: one item per cycle, sustained while m_axis_tready stays high.
// Stall: while the result register is held by a low m_axis_tready, one more item is
// taken into the input register and s_axis_tready then drops until the result
// moves on. Reset clears both registers' valid flags, all pending requests, puts
// the car at floor 0, idle and stopped, and loads the configuration defaults
// (top floor 63, travel 2 ticks, door 5 ticks).
module elevator_look_scheduler (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,  // [5:0] req_floor
  input  logic                                  s_axis_tuser,  // [0] opcode
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [5:0] car_floor, [7:6] car_direction, [8] car_moving, [9] door_open,
  // [15:10] goal_floor, [17:16] request_status
  output logic [elsch_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [elsch_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [elsch_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic                                in_valid_q;
  elsch_pkg::op_e                      in_op_q;
  logic [elsch_pkg::FLOOR_W-1:0]       in_floor_q;
  logic                                out_valid_q;
  elsch_pkg::res_t                     out_res_q;
  elsch_pkg::res_t                     res;
  logic                                advance;
  logic [elsch_pkg::FLOOR_W-1:0]       top_floor_q;
  logic [elsch_pkg::TICK_W-1:0]        travel_q;
  logic [elsch_pkg::TICK_W-1:0]        door_q;
  logic                                cfg_xfer;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign cfg_xfer      = cfg_valid_i && cfg_ready_o;

  elsch_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .commit_i       (advance),
    .op_i           (in_op_q),
    .req_floor_i    (in_floor_q),
    .top_floor_i    (top_floor_q),
    .travel_ticks_i (travel_q),
    .door_ticks_i   (door_q),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q    <= elsch_pkg::op_e'(s_axis_tuser);
      in_floor_q <= s_axis_tdata[elsch_pkg::FLOOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_floor_q <= elsch_pkg::TOP_MAX;
      travel_q    <= elsch_pkg::TICK_W'(2);
      door_q      <= elsch_pkg::TICK_W'(5);
    end else if (cfg_xfer) begin
      case (cfg_index_i)
        elsch_pkg::CFG_TOP_FLOOR: top_floor_q <= cfg_data_i[elsch_pkg::FLOOR_W-1:0];
        elsch_pkg::CFG_TRAVEL:    travel_q    <= cfg_data_i[elsch_pkg::TICK_W-1:0];
        elsch_pkg::CFG_DOOR:      door_q      <= cfg_data_i[elsch_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(elsch_pkg::OUT_DATA_W - elsch_pkg::RES_W)'(0), out_res_q};

endmodule

### hw/rtl/elsch_checker.sv
// Port-level checks for the elevator scheduler, bound to the top level.
module elsch_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [elsch_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  // A stalled result transfer keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Padding is zero and the heading is a legal code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0 && m_axis_tdata[7:6] != 2'd3)
    else $error("bad padding or heading code");

  // The car is never moving with the door open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
    else $error("moving with door open");

  // A stopped car reports no goal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] && !m_axis_tdata[9] |-> m_axis_tdata[15:10] == 6'd0)
    else $error("goal reported while stopped");

  // The door only opens at the goal floor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[5:0] == m_axis_tdata[15:10])
    else $error("door open away from goal");

endmodule

bind elevator_look_scheduler elsch_checker u_elsch_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
